### src/kli_pkg.sv
// Shared types and constants for the keyframe leg interpolator.
package kli_pkg;

    localparam int STORE_DEPTH_DEF = 64;
    localparam int LEG_COUNT_DEF   = 4;
    localparam int TIME_W  = 20;
    localparam int COORD_W = 12;
    localparam int LEG_W   = 2;
    localparam int ENTRY_W = TIME_W + LEG_W + 3 * COORD_W;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_EVAL   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEG_START,
        ST_READ,
        ST_CHECK,
        ST_DIV_START,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Controller -> datapath commands.
    typedef struct packed {
        logic do_append;
        logic do_clear;
        logic leg_start;
        logic mem_rd;
        logic check;
        logic div_start;
        logic emit;
        logic out_take;
    } cmd_t;

    // Datapath -> controller status.
    typedef struct packed {
        logic walk_done;
        logic end_found;
        logic need_div;
        logic div_done;
        logic last_leg;
        logic out_busy;
    } status_t;

endpackage

### src/kli_if.sv
// Valid/ready channel interfaces for input requests and leg results.
interface kli_in_if;
    import kli_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [1:0]                action;
    logic [TIME_W-1:0]         key_time;
    logic [LEG_W-1:0]          key_leg;
    logic signed [COORD_W-1:0] key_x;
    logic signed [COORD_W-1:0] key_y;
    logic signed [COORD_W-1:0] key_z;
    modport source (output valid, action, key_time, key_leg, key_x, key_y, key_z,
                    input ready);
    modport sink   (input valid, action, key_time, key_leg, key_x, key_y, key_z,
                    output ready);
endinterface

interface kli_out_if;
    import kli_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [LEG_W-1:0]          out_leg;
    logic                      leg_valid;
    logic [TIME_W-1:0]         out_time;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      last_leg;
    modport source (output valid, out_leg, leg_valid, out_time, pos_x, pos_y, pos_z,
                    last_leg, input ready);
    modport sink   (input valid, out_leg, leg_valid, out_time, pos_x, pos_y, pos_z,
                    last_leg, output ready);
endinterface

### src/kli_ram.sv
// Generic single-port-write, registered-read RAM.
module kli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

### src/kli_div.sv
// Signed restoring divider: quotient truncated toward zero, one bit per cycle.
module kli_div
    import kli_pkg::*;
#(
    parameter int NW = 34,
    parameter int DW = 21
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic [DW-1:0]        den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;
    logic [DW:0]   sub;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[DW-1:0], q_reg[NW-1]};
        sub       = trial - {1'b0, d_reg};
        if (start)
        begin
            neg_next  = num[NW-1];
            q_next    = num[NW-1] ? NW'(-num) : NW'(num);
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!sub[DW])
            begin
                r_next = sub;
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done = !busy_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule

### src/kli_ctrl.sv
// Evaluation sequencer: walks the store per leg, runs divisions, issues results.
module kli_ctrl
    import kli_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic [1:0] in_action,
    output logic    in_ready,
    input  status_t sts,
    output cmd_t    cmd
);
    state_t state_reg, state_next;
    logic [1:0] divn_reg, divn_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            divn_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            divn_reg  <= divn_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        divn_next  = divn_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_action == ACT_EVAL)
                begin
                    state_next = ST_LEG_START;
                end
            end
            ST_LEG_START: state_next = ST_READ;
            ST_READ:
            begin
                // walk ends at the end keyframe or past the last stored entry
                if (sts.end_found || sts.walk_done)
                begin
                    divn_next  = '0;
                    state_next = sts.need_div ? ST_DIV_START : ST_EMIT;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: state_next = ST_READ;
            ST_DIV_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    if (divn_reg == 2'd2)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        divn_next  = divn_reg + 2'd1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = sts.last_leg ? ST_IDLE : ST_LEG_START;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.do_clear = in_valid && in_action == ACT_CLEAR;
                cmd.do_append = in_valid && in_action == ACT_APPEND;
                cmd.leg_start = in_valid && in_action == ACT_EVAL;
            end
            ST_LEG_START: cmd.mem_rd = 1'b0;
            ST_READ:      cmd.mem_rd = !(sts.end_found || sts.walk_done);
            ST_CHECK:     cmd.check = 1'b1;
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DIV:       cmd.out_take = sts.div_done;
            ST_EMIT:      cmd.emit = !sts.out_busy;
            default:      cmd = '0;
        endcase
    end
endmodule

### src/kli_dp.sv
// Datapath: keyframe store, walk pointer, begin/end capture, divider, output register.
module kli_dp
    import kli_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int LEG_COUNT   = LEG_COUNT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    kli_in_if.sink   req,
    kli_out_if.source res,
    input  cmd_t     cmd,
    output status_t  sts
);
    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int CNW = $clog2(STORE_DEPTH + 1);
    localparam int LW  = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
    localparam int NW  = COORD_W + TIME_W + 2;
    localparam int DW  = TIME_W + 1;

    logic [CNW-1:0] count_reg, count_next;
    logic [CNW-1:0] ptr_reg;
    logic [LW-1:0]  leg_reg;
    logic [TIME_W-1:0] qt_reg;
    logic           b_ok_reg, e_ok_reg;
    logic [ENTRY_W-1:0] b_reg, e_reg, rdata;
    logic [1:0]     dsel_reg;
    logic signed [COORD_W-1:0] p_reg [3];
    logic           ov_reg;
    logic [LEG_W-1:0] o_leg_reg;
    logic           o_lv_reg, o_last_reg;
    logic [TIME_W-1:0] o_time_reg;
    logic signed [COORD_W-1:0] o_p_reg [3];
    logic           we;
    logic [ENTRY_W-1:0] wdata;
    logic [TIME_W-1:0] r_t;
    logic [LEG_W-1:0] r_leg;
    logic           hit_leg;
    logic signed [COORD_W-1:0] bc, ec;
    logic [TIME_W-1:0] bt, et;
    logic [DW-1:0]  den;
    logic signed [NW-1:0] num;
    logic           div_done;
    logic signed [NW-1:0] quo;
    logic           mult_go;
    logic signed [COORD_W+DW-1:0] pa, pb;

    // entry: {time, leg, x, y, z}
    assign wdata = {req.key_time, req.key_leg, req.key_x, req.key_y, req.key_z};
    assign we    = cmd.do_append && (count_reg < CNW'(STORE_DEPTH));

    kli_ram #(.WIDTH(ENTRY_W), .DEPTH(STORE_DEPTH)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wdata),
        .re    (cmd.mem_rd),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign r_t     = rdata[ENTRY_W-1 -: TIME_W];
    assign r_leg   = rdata[3*COORD_W +: LEG_W];
    assign hit_leg = ({{(LW+LEG_W){1'b0}}, r_leg} == {{(LW+LEG_W){1'b0}}, leg_reg});

    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_clear)
        begin
            count_next = '0;
        end
        else if (we)
        begin
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // coordinate select for the division in progress
    always_comb
    begin
        unique case (dsel_reg)
            2'd0:    begin bc = b_reg[2*COORD_W +: COORD_W]; ec = e_reg[2*COORD_W +: COORD_W]; end
            2'd1:    begin bc = b_reg[COORD_W +: COORD_W];   ec = e_reg[COORD_W +: COORD_W];   end
            default: begin bc = b_reg[0 +: COORD_W];         ec = e_reg[0 +: COORD_W];         end
        endcase
    end
    assign bt  = b_reg[ENTRY_W-1 -: TIME_W];
    assign et  = e_reg[ENTRY_W-1 -: TIME_W];
    assign den = DW'(et) - DW'(bt);
    assign mult_go = cmd.div_start;
    // b*den + (e-b)*(t-tb) = b*(te-t) + e*(t-tb); both weights nonnegative
    assign pa  = bc * $signed({1'b0, et - qt_reg});
    assign pb  = ec * $signed({1'b0, qt_reg - bt});
    assign num = NW'(pa) + NW'(pb);

    kli_div #(.NW(NW), .DW(DW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mult_go),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quo   (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.leg_start)
        begin
            qt_reg  <= req.key_time;
            leg_reg <= '0;
        end
        else if (cmd.emit)
        begin
            leg_reg <= leg_reg + 1'b1;
        end
        if (cmd.leg_start || cmd.emit)
        begin
            ptr_reg  <= '0;
            b_ok_reg <= 1'b0;
            e_ok_reg <= 1'b0;
            dsel_reg <= '0;
        end
        else if (cmd.mem_rd)
        begin
            ptr_reg <= ptr_reg + 1'b1;
        end
        if (cmd.check && hit_leg)
        begin
            if (qt_reg < r_t)
            begin
                e_reg    <= rdata;
                e_ok_reg <= 1'b1;
            end
            else
            begin
                b_reg    <= rdata;
                b_ok_reg <= 1'b1;
            end
        end
        if (cmd.out_take)
        begin
            p_reg[dsel_reg] <= quo[COORD_W-1:0];
            dsel_reg        <= dsel_reg + 2'd1;
        end
        if (cmd.emit)
        begin
            o_leg_reg  <= LEG_W'(leg_reg);
            o_lv_reg   <= b_ok_reg || e_ok_reg;
            o_time_reg <= qt_reg;
            o_last_reg <= sts.last_leg;
            for (int j = 0; j < 3; j++)
            begin
                if (b_ok_reg && e_ok_reg)
                begin
                    o_p_reg[j] <= p_reg[j];
                end
                else if (e_ok_reg)
                begin
                    o_p_reg[j] <= e_reg[(2-j)*COORD_W +: COORD_W];
                end
                else if (b_ok_reg)
                begin
                    o_p_reg[j] <= b_reg[(2-j)*COORD_W +: COORD_W];
                end
                else
                begin
                    o_p_reg[j] <= '0;
                end
            end
        end
    end

    assign sts.walk_done   = ptr_reg >= count_reg;
    assign sts.end_found   = e_ok_reg;
    assign sts.need_div    = b_ok_reg && e_ok_reg;
    assign sts.div_done    = div_done;
    assign sts.last_leg    = (leg_reg == LW'(LEG_COUNT - 1));
    assign sts.out_busy    = ov_reg && !res.ready;

    assign res.valid     = ov_reg;
    assign res.out_leg   = o_leg_reg;
    assign res.leg_valid = o_lv_reg;
    assign res.out_time  = o_time_reg;
    assign res.pos_x     = o_p_reg[0];
    assign res.pos_y     = o_p_reg[1];
    assign res.pos_z     = o_p_reg[2];
    assign res.last_leg  = o_last_reg;
endmodule

### src/keyframe_leg_interpolator_core.sv
// Top level of the keyframe leg interpolator.
//
// Requests arrive on the in channel (valid/ready). Clear and append requests
// are taken while the sequencer is idle; an append to a full store is dropped. An evaluate request
// yields LEG_COUNT results on the out channel, legs in ascending order, the
// last one flagged by last_leg.
// Per leg the sequencer reads the keyframe store one entry at a time, each
// registered RAM read followed by a check of that entry, until the end
// keyframe is found or the stored entries run out, then runs three divisions
// when the query falls between two keyframes. No new request is taken until
// the last result of an evaluation is in the output register.
// Reset empties the store (count to zero) and idles the sequencer; store
// contents are not cleared. Results sit in a one-entry output register; a
// stalled receiver holds the sequencer before the next leg's result until the held one is taken.
module keyframe_leg_interpolator_core
    import kli_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int LEG_COUNT   = LEG_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    kli_in_if.sink    req,
    kli_out_if.source res
);
    cmd_t    cmd;
    status_t sts;
    logic    ctrl_ready;

    kli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_action (req.action),
        .in_ready  (ctrl_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    assign req.ready = ctrl_ready;

    kli_dp #(.STORE_DEPTH(STORE_DEPTH), .LEG_COUNT(LEG_COUNT)) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cmd   (cmd),
        .sts   (sts)
    );
endmodule
